>>> rtl/core/idcs_pkg.sv
// idcs_pkg: shared types and constants for the display command sequencer
// depends on nothing; imported by every module under rtl/core
`timescale 1ns / 1ps

package idcs_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;

    localparam int BYTE_W      = 8;
    localparam int OP_W        = 2;
    localparam int ACT_W       = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int WAIT_W      = 16;
    localparam int CFG_INDEX_W = 4;

    // request opcodes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd2;

    // bus actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEND  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT = 4'd3;

    // wait codes
    localparam logic [BYTE_W-1:0] WAIT_CODE_NONE   = 8'd0;
    localparam logic [BYTE_W-1:0] WAIT_CODE_SHORT  = 8'd1;
    localparam logic [BYTE_W-1:0] WAIT_CODE_MEDIUM = 8'd2;
    localparam logic [BYTE_W-1:0] WAIT_CODE_LONG   = 8'd3;

    localparam logic [WAIT_W-1:0] SHORT_WAIT_RST   = 16'd2;
    localparam logic [WAIT_W-1:0] MEDIUM_WAIT_RST  = 16'd25;
    localparam logic [WAIT_W-1:0] LONG_WAIT_RST    = 16'd800;
    localparam logic [WAIT_W-1:0] DEFAULT_WAIT_RST = 16'd1;

    typedef struct packed {
        logic [ACT_W-1:0]       action;
        logic [BYTE_W-1:0]      send_byte;
        logic                   push_dropped;
        logic [COUNT_OUT_W-1:0] queue_count;
    } result_t;

endpackage

>>> rtl/core/idcs_queue_mem.sv
// idcs_queue_mem: byte queue storage, one write port and two registered read ports
// depends on idcs_pkg; a write to an address read in the same cycle is forwarded
`timescale 1ns / 1ps

module idcs_queue_mem #(
    parameter int QUEUE_DEPTH = idcs_pkg::QUEUE_DEPTH_DEF,
    parameter int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [idcs_pkg::BYTE_W-1:0] wdata,
    input  logic [AW-1:0]             raddr0,
    input  logic [AW-1:0]             raddr1,
    output logic [idcs_pkg::BYTE_W-1:0] rdata0,
    output logic [idcs_pkg::BYTE_W-1:0] rdata1
);
    import idcs_pkg::*;

    logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0] rd0_reg;
    logic [BYTE_W-1:0] rd1_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic              fwd0_reg;
    logic              fwd1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd0_reg      <= mem[raddr0];
        rd1_reg      <= mem[raddr1];
        fwd_data_reg <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd0_reg <= 1'b0;
            fwd1_reg <= 1'b0;
        end else begin
            fwd0_reg <= we && (waddr == raddr0);
            fwd1_reg <= we && (waddr == raddr1);
        end
    end

    // read-during-write returns the old entry, so take the new byte instead
    assign rdata0 = fwd0_reg ? fwd_data_reg : rd0_reg;
    assign rdata1 = fwd1_reg ? fwd_data_reg : rd1_reg;

endmodule

>>> rtl/core/idcs_seq_core.sv
// idcs_seq_core: queue pointers, phase machine, wait counter and config registers
// depends on idcs_pkg; reads head bytes prefetched by idcs_queue_mem
`timescale 1ns / 1ps

module idcs_seq_core #(
    parameter int QUEUE_DEPTH = idcs_pkg::QUEUE_DEPTH_DEF,
    parameter int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [idcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [idcs_pkg::WAIT_W-1:0]     cfg_wdata,
    input  logic                            item_valid,
    input  logic [idcs_pkg::OP_W-1:0]       op,
    input  logic [idcs_pkg::BYTE_W-1:0]     push_byte,
    input  logic                            bus_busy,
    input  logic [idcs_pkg::BYTE_W-1:0]     head0,
    input  logic [idcs_pkg::BYTE_W-1:0]     head1,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [idcs_pkg::BYTE_W-1:0]     mem_wdata,
    output logic [AW-1:0]                   mem_raddr0,
    output logic [AW-1:0]                   mem_raddr1,
    output idcs_pkg::result_t               result
);
    import idcs_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SEND  = 3'd2,
        PH_STOP  = 3'd3,
        PH_WAIT  = 3'd4
    } phase_t;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              sent_ready_reg, sent_ready_next;
    logic [WAIT_W-1:0] short_reg, medium_reg, long_reg, default_reg;

    logic [AW-1:0]     rp_inc1, rp_inc2;
    logic              has1, has2, full;
    logic [BYTE_W-1:0] pop_byte, wait_code;
    logic [WAIT_W-1:0] wait_ticks;

    assign rp_inc1   = wrap_inc(rp_reg);
    assign rp_inc2   = wrap_inc(rp_inc1);
    assign has1      = (count_reg != '0);
    assign has2      = (count_reg >= CW'(2));
    assign full      = (count_reg >= CW'(QUEUE_DEPTH));
    assign pop_byte  = has1 ? head0 : '0;
    assign wait_code = has2 ? head1 : '0;

    always_comb begin
        unique case (wait_code)
            WAIT_CODE_NONE:   wait_ticks = '0;
            WAIT_CODE_SHORT:  wait_ticks = short_reg;
            WAIT_CODE_MEDIUM: wait_ticks = medium_reg;
            WAIT_CODE_LONG:   wait_ticks = long_reg;
            default:          wait_ticks = default_reg;
        endcase
    end

    always_comb begin
        phase_next          = phase_reg;
        rp_next             = rp_reg;
        wp_next             = wp_reg;
        count_next          = count_reg;
        wait_next           = wait_reg;
        sent_ready_next     = sent_ready_reg;
        mem_we              = 1'b0;
        result.action       = ACT_NONE;
        result.send_byte    = '0;
        result.push_dropped = 1'b0;
        if (item_valid) begin
            unique case (op)
                OP_PUSH: begin
                    if (full) begin
                        result.push_dropped = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        wp_next    = wrap_inc(wp_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_TICK: begin
                    if (!bus_busy) begin
                        unique case (phase_reg)
                            PH_IDLE: begin
                                if (has1) begin
                                    phase_next = PH_START;
                                end
                            end
                            PH_START: begin
                                sent_ready_next = 1'b1;
                                result.action   = ACT_START;
                                phase_next      = PH_SEND;
                            end
                            PH_SEND: begin
                                if (sent_ready_reg) begin
                                    if (pop_byte != '0) begin
                                        rp_next          = rp_inc1;
                                        count_next       = count_reg - 1'b1;
                                        sent_ready_next  = 1'b0;
                                        result.action    = ACT_SEND;
                                        result.send_byte = pop_byte;
                                    end else begin
                                        // marker then wait code, each popped only if held
                                        if (has2) begin
                                            rp_next    = rp_inc2;
                                            count_next = count_reg - CW'(2);
                                        end else if (has1) begin
                                            rp_next    = rp_inc1;
                                            count_next = count_reg - 1'b1;
                                        end
                                        wait_next  = wait_ticks;
                                        phase_next = PH_STOP;
                                    end
                                end
                            end
                            PH_STOP: begin
                                result.action = ACT_STOP;
                                phase_next    = PH_WAIT;
                            end
                            PH_WAIT: begin
                                if (wait_reg == '0) begin
                                    phase_next = PH_IDLE;
                                end else begin
                                    wait_next = wait_reg - 1'b1;
                                end
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                end
                OP_ACK: sent_ready_next = 1'b1;
                default: ;
            endcase
        end
        result.queue_count = COUNT_OUT_W'(count_next);
    end

    // prefetch the two head entries for the next item
    assign mem_waddr  = wp_reg;
    assign mem_wdata  = push_byte;
    assign mem_raddr0 = aresetn ? rp_next : '0;
    assign mem_raddr1 = wrap_inc(mem_raddr0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            wait_reg       <= '0;
            sent_ready_reg <= 1'b0;
            short_reg      <= SHORT_WAIT_RST;
            medium_reg     <= MEDIUM_WAIT_RST;
            long_reg       <= LONG_WAIT_RST;
            default_reg    <= DEFAULT_WAIT_RST;
        end else begin
            phase_reg      <= phase_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            wait_reg       <= wait_next;
            sent_ready_reg <= sent_ready_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SHORT:   short_reg   <= cfg_wdata;
                    CFG_MEDIUM:  medium_reg  <= cfg_wdata;
                    CFG_LONG:    long_reg    <= cfg_wdata;
                    CFG_DEFAULT: default_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> rtl/core/idcs_out_skid.sv
// idcs_out_skid: two-entry result buffer between the sequencer and the result channel
// depends on idcs_pkg for result_t
`timescale 1ns / 1ps

module idcs_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  idcs_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    output idcs_pkg::result_t out_data,
    input  logic              out_ready
);
    import idcs_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    take;

    assign take      = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg) begin
                if (take) begin
                    main_reg       <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_valid) begin
                if (!main_valid_reg || take) begin
                    main_reg       <= in_data;
                    main_valid_reg <= 1'b1;
                end else begin
                    // stalled result stays, new one parks in the skid slot
                    skid_reg       <= in_data;
                    skid_valid_reg <= 1'b1;
                end
            end else if (take) begin
                main_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/i2c_display_command_sequencer.sv
// channel   | direction | ports                                         | handshake
// request   | in        | s_op, s_push_byte, s_bus_busy                 | s_valid / s_ready
// result    | out       | m_action, m_send_byte, m_push_dropped, m_queue_count | m_valid / m_ready
// config    | in        | cfg_index, cfg_wdata                          | cfg_we, no wait
//
// one request accepted every cycle while s_ready is high; its result is registered
// the queue memory prefetches the two head bytes each cycle through its two read ports,
// with write forwarding, so a pop never waits on the registered read
// the queue store is not cleared on reset
// a two-entry result buffer keeps s_ready high through a single stalled result
//
// top level of the display command sequencer; depends on idcs_pkg, idcs_queue_mem,
// idcs_seq_core and idcs_out_skid
`timescale 1ns / 1ps

module i2c_display_command_sequencer #(
    parameter int QUEUE_DEPTH = idcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [idcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [idcs_pkg::WAIT_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [idcs_pkg::OP_W-1:0]         s_op,
    input  logic [idcs_pkg::BYTE_W-1:0]       s_push_byte,
    input  logic                              s_bus_busy,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [idcs_pkg::ACT_W-1:0]        m_action,
    output logic [idcs_pkg::BYTE_W-1:0]       m_send_byte,
    output logic                              m_push_dropped,
    output logic [idcs_pkg::COUNT_OUT_W-1:0]  m_queue_count
);
    import idcs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic              accept;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr0, mem_raddr1;
    logic [BYTE_W-1:0] mem_wdata, head0, head1;
    result_t           core_result;
    result_t           out_result;

    assign accept = s_valid && s_ready;

    idcs_queue_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .AW         (AW)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (head0),
        .rdata1 (head1)
    );

    idcs_seq_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .AW         (AW)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_valid(accept),
        .op        (s_op),
        .push_byte (s_push_byte),
        .bus_busy  (s_bus_busy),
        .head0     (head0),
        .head1     (head1),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr0(mem_raddr0),
        .mem_raddr1(mem_raddr1),
        .result    (core_result)
    );

    idcs_out_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_data  (core_result),
        .in_ready (s_ready),
        .out_valid(m_valid),
        .out_data (out_result),
        .out_ready(m_ready)
    );

    assign m_action       = out_result.action;
    assign m_send_byte    = out_result.send_byte;
    assign m_push_dropped = out_result.push_dropped;
    assign m_queue_count  = out_result.queue_count;

`ifndef SYNTH
    // a sent byte is never the zero marker, and other actions carry no byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_action == ACT_SEND) == (m_send_byte != '0)))
        else $error("send byte does not match action");

    // a dropped request only happens with the queue full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_push_dropped) |->
            (m_queue_count == COUNT_OUT_W'(QUEUE_DEPTH) && m_action == ACT_NONE))
        else $error("push dropped with room in the queue");

    // the request side only stalls when a result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("request side stalled with no result pending");

    // a request taken behind a stalled result fills the skid slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_valid && !m_ready) |=> !s_ready)
        else $error("skid slot not filled behind stalled result");
`endif

endmodule
